// ===== design/sitoa_pkg.sv =====
// Package for the signed integer to decimal text converter.
// Holds the microcode format, the microcode table, the text constants and sizing helpers.
// No dependencies.
package sitoa_pkg;

	localparam int DEF_VALUE_WIDTH = 64;
	localparam int PC_W            = 3;

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	// Double-dabble correction: a BCD digit of five or more gets three added before a shift.
	localparam logic [3:0] BCD_ADJUST_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJUST     = 4'd3;

	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [2:0] {
		OP_LOAD   = 3'd0,
		OP_DABBLE = 3'd1,
		OP_SKIP   = 3'd2,
		OP_SIGN   = 3'd3,
		OP_DIGIT  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		COND_NEVER       = 2'd0,
		COND_BITS_LEFT   = 2'd1,
		COND_LEAD_ZERO   = 2'd2,
		COND_DIGITS_LEFT = 2'd3
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   jump;
		pc_t   next;
	} ucode_t;

	// Datapath flags that the sequencer looks at.
	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic negative;
		logic bits_left;
		logic lead_zero;
		logic digits_left;
	} status_t;

	// Control handed to the datapath for the current step.
	typedef struct packed {
		op_t  op;
		logic fire;
		logic again;
	} ctl_t;

	localparam pc_t PC_LOAD   = 3'd0;
	localparam pc_t PC_DABBLE = 3'd1;
	localparam pc_t PC_SKIP   = 3'd2;
	localparam pc_t PC_SIGN   = 3'd3;
	localparam pc_t PC_DIGIT  = 3'd4;

	function automatic ucode_t ucode_word(input pc_t pc);
		ucode_t w;
		unique case (pc)
			PC_LOAD:   w = '{OP_LOAD,   COND_NEVER,       PC_LOAD,   PC_DABBLE};
			PC_DABBLE: w = '{OP_DABBLE, COND_BITS_LEFT,   PC_DABBLE, PC_SKIP};
			PC_SKIP:   w = '{OP_SKIP,   COND_LEAD_ZERO,   PC_SKIP,   PC_SIGN};
			PC_SIGN:   w = '{OP_SIGN,   COND_NEVER,       PC_SIGN,   PC_DIGIT};
			PC_DIGIT:  w = '{OP_DIGIT,  COND_DIGITS_LEFT, PC_DIGIT,  PC_LOAD};
			default:   w = '{OP_LOAD,   COND_NEVER,       PC_LOAD,   PC_LOAD};
		endcase
		return w;
	endfunction

	// Decimal digits of 2^(w-1), the largest magnitude; 30103/100000 approximates log10(2).
	function automatic int num_digits(input int w);
		return ((w - 1) * 30103) / 100000 + 1;
	endfunction

endpackage

// ===== design/signed_int_to_decimal_ascii_top.sv =====
// Top level of the signed integer to decimal text converter: datapath and output register.
// Depends on sitoa_pkg and sitoa_seq.

// Each request carries one signed integer whose low VALUE_WIDTH bits are taken as a two's
// complement value; the block answers with its decimal text one character per output request,
// most significant first, with a leading '-' for negative values and no leading zeros, and
// last_char set on the final character. One request is worked on at a time, in microcode steps:
// one step to load, one shift-add double-dabble step per input bit, one step per leading zero
// digit dropped plus one, one sign step, and one step per digit sent; a digit step, or the sign
// step of a negative value, waits while the output register is full and stalled. The digit
// capacity is 19 at VALUE_WIDTH = 64. The single output register lets the last character
// wait for the receiver while the next request is accepted.
module signed_int_to_decimal_ascii_top #(
	parameter int VALUE_WIDTH = sitoa_pkg::DEF_VALUE_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  character,
	output logic        last_char
);
	import sitoa_pkg::*;

	localparam int NDIG = num_digits(VALUE_WIDTH);
	localparam int BW   = $clog2(VALUE_WIDTH + 1);
	localparam int CW   = $clog2(NDIG + 1);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [3:0]             digit_q [NDIG];
	logic [3:0]             adj     [NDIG];
	logic [BW-1:0]          bit_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q;
	logic                   out_valid_q;
	logic [7:0]             char_q;
	logic                   last_q;

	logic [VALUE_WIDTH-1:0] v;
	logic [VALUE_WIDTH-1:0] mag_in;
	logic                   neg_in;
	logic                   out_free;
	logic                   emit;
	logic [7:0]             emit_char;
	logic                   emit_last;
	logic                   shift_digits;
	status_t                status;
	ctl_t                   ctl;

	sitoa_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctl    (ctl)
	);

	assign v      = value[VALUE_WIDTH-1:0];
	assign neg_in = v[VALUE_WIDTH-1];
	// Unsigned negation, so the most negative value gives 2^(VALUE_WIDTH-1) exactly.
	assign mag_in = neg_in ? (~v + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : v;

	assign out_free = !out_valid_q || !out_stall;

	assign status.in_valid    = in_valid;
	assign status.out_free    = out_free;
	assign status.negative    = neg_q;
	assign status.bits_left   = bit_q != BW'(1);
	assign status.lead_zero   = (digit_q[NDIG-1] == 4'd0) && (cnt_q > CW'(1));
	assign status.digits_left = cnt_q > CW'(1);

	assign in_stall = ctl.op != OP_LOAD;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (digit_q[i] >= BCD_ADJUST_MIN) ? (digit_q[i] + BCD_ADJUST) : digit_q[i];
		end
	end

	always_comb begin
		emit      = 1'b0;
		emit_char = ASCII_ZERO + {4'd0, digit_q[NDIG-1]};
		emit_last = cnt_q == CW'(1);
		if (ctl.fire && ctl.op == OP_SIGN && neg_q) begin
			emit      = 1'b1;
			emit_char = ASCII_MINUS;
			emit_last = 1'b0;
		end else if (ctl.fire && ctl.op == OP_DIGIT) begin
			emit = 1'b1;
		end
	end

	assign shift_digits = ctl.fire &&
		((ctl.op == OP_SKIP && ctl.again) || ctl.op == OP_DIGIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= '0;
			bit_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
		end else if (ctl.fire) begin
			if (ctl.op == OP_LOAD) begin
				mag_q <= mag_in;
				bit_q <= BW'(VALUE_WIDTH);
				cnt_q <= CW'(NDIG);
				neg_q <= neg_in;
			end else if (ctl.op == OP_DABBLE) begin
				mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
				bit_q <= bit_q - BW'(1);
			end else if (shift_digits) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// BCD digits, most significant on top; shifted up to drop leading zeros and send text.
	always_ff @(posedge clk) begin
		if (ctl.fire && ctl.op == OP_LOAD) begin
			for (int i = 0; i < NDIG; i++) begin
				digit_q[i] <= 4'd0;
			end
		end else if (ctl.fire && ctl.op == OP_DABBLE) begin
			digit_q[0] <= {adj[0][2:0], mag_q[VALUE_WIDTH-1]};
			for (int i = 1; i < NDIG; i++) begin
				digit_q[i] <= {adj[i][2:0], adj[i-1][3]};
			end
		end else if (shift_digits) begin
			digit_q[0] <= 4'd0;
			for (int i = 1; i < NDIG; i++) begin
				digit_q[i] <= digit_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last_char = last_q;

	a_load_starts_conversion: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ctl.op == OP_DABBLE && bit_q == BW'(VALUE_WIDTH))
		else $error("accepted request did not start the conversion");

	a_sign_never_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && character == ASCII_MINUS |-> !last_char)
		else $error("minus sign flagged as the last character");

	a_digit_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == OP_DIGIT || ctl.op == OP_SIGN || ctl.op == OP_SKIP |-> cnt_q != '0)
		else $error("digit count ran out while text remains");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("character written over a pending one");

endmodule

// ===== design/sitoa_seq.sv =====
// Microcode sequencer for the decimal text converter: step counter, control table, jumps.
// Depends on sitoa_pkg.
module sitoa_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  sitoa_pkg::status_t status,
	output sitoa_pkg::ctl_t    ctl
);
	import sitoa_pkg::*;

	pc_t    pc_q;
	ucode_t word;
	logic   go;
	logic   again;

	assign word = ucode_word(pc_q);

	// A step completes when its operation can make progress this cycle.
	always_comb begin
		unique case (word.op)
			OP_LOAD:   go = status.in_valid;
			OP_DABBLE: go = 1'b1;
			OP_SKIP:   go = 1'b1;
			OP_SIGN:   go = !status.negative || status.out_free;
			OP_DIGIT:  go = status.out_free;
			default:   go = 1'b0;
		endcase
	end

	always_comb begin
		unique case (word.cond)
			COND_NEVER:       again = 1'b0;
			COND_BITS_LEFT:   again = status.bits_left;
			COND_LEAD_ZERO:   again = status.lead_zero;
			COND_DIGITS_LEFT: again = status.digits_left;
			default:          again = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_LOAD;
		end else if (go) begin
			pc_q <= again ? word.jump : word.next;
		end
	end

	assign ctl.op    = word.op;
	assign ctl.fire  = go;
	assign ctl.again = again;

endmodule
